/* sv/sqc_pkg.sv */
// Shared types and constants for the quaternion smallest-three codec.
// No dependencies; imported by every module of the block.
package sqc_pkg;

    // Operation carried by each item
    typedef enum logic {
        OP_PACK   = 1'b0,
        OP_UNPACK = 1'b1
    } sqc_op_t;

    localparam logic [31:0] FULL_SCALE_SQ = 32'h4000_0000;
    localparam logic [15:0] ROOT_MAX      = 16'h7FFF;
    localparam int          ROOT_STAGES   = 8;   // two root bits per stage

    // Front stage result: pack outcome plus the three squares for unpack
    typedef struct packed {
        sqc_op_t          op;
        logic [1:0]       idx;
        logic             sign;
        logic [2:0][15:0] comp;
        logic [2:0][30:0] sq;
    } sqc_front_t;

    // Root pipeline word
    typedef struct packed {
        sqc_op_t          op;
        logic [1:0]       idx;
        logic             sign;
        logic [2:0][15:0] comp;
        logic             zero;   // sum of squares reached full scale
        logic [31:0]      rad;    // radicand, consumed two bits per step
        logic [16:0]      rem;
        logic [15:0]      root;
    } sqc_pipe_t;

    // One digit-recurrence step of the square root
    function automatic sqc_pipe_t sqrt_step(sqc_pipe_t p);
        sqc_pipe_t   r;
        logic [18:0] rem_s;
        logic [18:0] trial;
        logic [18:0] diff;
        r     = p;
        rem_s = {p.rem, p.rad[31:30]};
        trial = {1'b0, p.root, 2'b01};
        diff  = rem_s - trial;
        if (rem_s >= trial)
        begin
            r.rem  = diff[16:0];
            r.root = {p.root[14:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_s[16:0];
            r.root = {p.root[14:0], 1'b0};
        end
        r.rad = {p.rad[29:0], 2'b00};
        return r;
    endfunction

endpackage

/* sv/quaternion_smallest_three_codec.sv */
// Top level of the quaternion smallest-three codec.
// Depends on sqc_pkg, sqc_front, sqc_sum, sqc_root_stage, sqc_back.
//
// Input channel: in_valid / in_stall with opcode and all input fields.
// opcode 0 packs quat_in_0..3 into three 14-bit kept fields plus the index
// and sign of the largest-magnitude component; opcode 1 unpacks kept_in_0..2,
// dropped_index_in and dropped_sign_in into quat_out_0..3, rebuilding the
// dropped component as the square root of full scale minus the sum of squares.
// Output channel: out_valid / out_stall; fields the operation does not use
// read zero.
//
// Pipeline from acceptance to out_valid: one front stage
// (component select and three 16x16 squares), one sum stage, eight root
// stages of two bits each, one output stage. One item is accepted per cycle while in_stall is low.
// Every stage holds its own valid bit, so bubbles close up under stall.
// When the receiver stalls the output register holds its item and the stall
// reaches the input only once every stage is full.
// Reset empties all stages; no item is in flight afterwards.
module quaternion_smallest_three_codec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [15:0] quat_in_0,
    input  logic signed [15:0] quat_in_1,
    input  logic signed [15:0] quat_in_2,
    input  logic signed [15:0] quat_in_3,
    input  logic [13:0]        kept_in_0,
    input  logic [13:0]        kept_in_1,
    input  logic [13:0]        kept_in_2,
    input  logic [1:0]         dropped_index_in,
    input  logic               dropped_sign_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [13:0]        kept_out_0,
    output logic [13:0]        kept_out_1,
    output logic [13:0]        kept_out_2,
    output logic [1:0]         dropped_index_out,
    output logic               dropped_sign_out,
    output logic signed [15:0] quat_out_0,
    output logic signed [15:0] quat_out_1,
    output logic signed [15:0] quat_out_2,
    output logic signed [15:0] quat_out_3
);
    import sqc_pkg::*;

    logic       front_ready;
    logic       front_valid;
    sqc_front_t front_data;
    logic       sum_ready;

    logic      pipe_valid [ROOT_STAGES+1];
    logic      pipe_ready [ROOT_STAGES+1];
    sqc_pipe_t pipe_data  [ROOT_STAGES+1];

    assign in_stall = !front_ready;

    sqc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (front_ready),
        .opcode           (opcode),
        .quat_in_0        (quat_in_0),
        .quat_in_1        (quat_in_1),
        .quat_in_2        (quat_in_2),
        .quat_in_3        (quat_in_3),
        .kept_in_0        (kept_in_0),
        .kept_in_1        (kept_in_1),
        .kept_in_2        (kept_in_2),
        .dropped_index_in (dropped_index_in),
        .dropped_sign_in  (dropped_sign_in),
        .out_valid        (front_valid),
        .out_ready        (sum_ready),
        .out_data         (front_data)
    );

    sqc_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (sum_ready),
        .in_data   (front_data),
        .out_valid (pipe_valid[0]),
        .out_ready (pipe_ready[0]),
        .out_data  (pipe_data[0])
    );

    // Square-root pipeline
    for (genvar s = 0; s < ROOT_STAGES; s++)
    begin : g_root
        sqc_root_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[s]),
            .in_ready  (pipe_ready[s]),
            .in_data   (pipe_data[s]),
            .out_valid (pipe_valid[s+1]),
            .out_ready (pipe_ready[s+1]),
            .out_data  (pipe_data[s+1])
        );
    end

    sqc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (pipe_valid[ROOT_STAGES]),
        .in_ready          (pipe_ready[ROOT_STAGES]),
        .in_data           (pipe_data[ROOT_STAGES]),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kept_out_0        (kept_out_0),
        .kept_out_1        (kept_out_1),
        .kept_out_2        (kept_out_2),
        .dropped_index_out (dropped_index_out),
        .dropped_sign_out  (dropped_sign_out),
        .quat_out_0        (quat_out_0),
        .quat_out_1        (quat_out_1),
        .quat_out_2        (quat_out_2),
        .quat_out_3        (quat_out_3)
    );

endmodule

/* sv/sqc_front.sv */
// Input stage: pack selection of the largest component and unpack squares.
// Depends on sqc_pkg.
module sqc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [15:0] quat_in_0,
    input  logic signed [15:0] quat_in_1,
    input  logic signed [15:0] quat_in_2,
    input  logic signed [15:0] quat_in_3,
    input  logic [13:0]        kept_in_0,
    input  logic [13:0]        kept_in_1,
    input  logic [13:0]        kept_in_2,
    input  logic [1:0]         dropped_index_in,
    input  logic               dropped_sign_in,
    output logic               out_valid,
    input  logic               out_ready,
    output sqc_pkg::sqc_front_t out_data
);
    import sqc_pkg::*;

    logic       valid_reg;
    sqc_front_t data_reg;
    sqc_front_t data_next;

    logic [3:0][15:0] q;
    logic [3:0][16:0] mag;
    logic [2:0][15:0] kraw;
    logic [1:0]       best;

    // Magnitudes, largest with first index winning ties
    always_comb
    begin
        logic signed [31:0] prod;
        q = {quat_in_3, quat_in_2, quat_in_1, quat_in_0};
        kraw = {{kept_in_2, 2'b00}, {kept_in_1, 2'b00}, {kept_in_0, 2'b00}};
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = q[i][15] ? (~{q[i][15], q[i]} + 17'd1) : {q[i][15], q[i]};
        end
        best = 2'd0;
        for (int i = 1; i < 4; i++)
        begin
            if (mag[i] > mag[best])
            begin
                best = 2'(i);
            end
        end

        data_next.op = sqc_op_t'(opcode);
        for (int j = 0; j < 3; j++)
        begin
            prod = $signed(kraw[j]) * $signed(kraw[j]);
            data_next.sq[j] = prod[30:0];
        end
        if (sqc_op_t'(opcode) == OP_PACK)
        begin
            data_next.idx     = best;
            data_next.sign    = q[best][15];
            data_next.comp[0] = (best == 2'd0) ? q[1] : q[0];
            data_next.comp[1] = (best <= 2'd1) ? q[2] : q[1];
            data_next.comp[2] = (best <= 2'd2) ? q[3] : q[2];
        end
        else
        begin
            data_next.idx  = dropped_index_in;
            data_next.sign = dropped_sign_in;
            data_next.comp = kraw;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* sv/sqc_sum.sv */
// Sum of squares and radicand setup for the root pipeline.
// Depends on sqc_pkg.
module sqc_sum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sqc_pkg::sqc_front_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sqc_pkg::sqc_pipe_t  out_data
);
    import sqc_pkg::*;

    logic      valid_reg;
    sqc_pipe_t data_reg;
    sqc_pipe_t data_next;

    // Sum never exceeds 3 * 2^30, so 32 bits hold it
    always_comb
    begin
        logic [31:0] sum;
        sum = {1'b0, in_data.sq[0]} + {1'b0, in_data.sq[1]} + {1'b0, in_data.sq[2]};
        data_next.op   = in_data.op;
        data_next.idx  = in_data.idx;
        data_next.sign = in_data.sign;
        data_next.comp = in_data.comp;
        data_next.zero = (sum >= FULL_SCALE_SQ);
        data_next.rad  = FULL_SCALE_SQ - sum;
        data_next.rem  = '0;
        data_next.root = '0;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* sv/sqc_root_stage.sv */
// One square-root pipeline stage: two digit-recurrence steps.
// Depends on sqc_pkg (sqrt_step).
module sqc_root_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sqc_pkg::sqc_pipe_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sqc_pkg::sqc_pipe_t out_data
);
    import sqc_pkg::*;

    logic      valid_reg;
    sqc_pipe_t data_reg;
    sqc_pipe_t data_next;

    assign data_next = sqrt_step(sqrt_step(in_data));

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    // Partial remainder stays within 2 * partial root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rem <= {data_reg.root, 1'b0}))
        else $error("root stage remainder out of bound");

endmodule

/* sv/sqc_back.sv */
// Output stage: saturate and sign the rebuilt component, place all fields.
// Depends on sqc_pkg.
module sqc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sqc_pkg::sqc_pipe_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [13:0]        kept_out_0,
    output logic [13:0]        kept_out_1,
    output logic [13:0]        kept_out_2,
    output logic [1:0]         dropped_index_out,
    output logic               dropped_sign_out,
    output logic signed [15:0] quat_out_0,
    output logic signed [15:0] quat_out_1,
    output logic signed [15:0] quat_out_2,
    output logic signed [15:0] quat_out_3
);
    import sqc_pkg::*;

    logic             valid_reg;
    sqc_op_t          op_reg;
    logic [2:0][13:0] kept_reg;
    logic [2:0][13:0] kept_next;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    logic             sign_reg;
    logic             sign_next;
    logic [3:0][15:0] quat_reg;
    logic [3:0][15:0] quat_next;

    // Result formatting
    always_comb
    begin
        logic [15:0] root;
        logic [15:0] last;
        logic [2:0][15:0] c;
        c    = in_data.comp;
        root = in_data.zero ? 16'd0 : in_data.root;
        if (root[15])
        begin
            root = ROOT_MAX;
        end
        last = in_data.sign ? (~root + 16'd1) : root;

        kept_next = '0;
        idx_next  = '0;
        sign_next = 1'b0;
        quat_next = '0;
        if (in_data.op == OP_PACK)
        begin
            for (int j = 0; j < 3; j++)
            begin
                kept_next[j] = c[j][15:2];
            end
            idx_next  = in_data.idx;
            sign_next = in_data.sign;
        end
        else
        begin
            quat_next[0] = (in_data.idx == 2'd0) ? last : c[0];
            quat_next[1] = (in_data.idx == 2'd1) ? last :
                           ((in_data.idx == 2'd0) ? c[0] : c[1]);
            quat_next[2] = (in_data.idx == 2'd2) ? last :
                           ((in_data.idx == 2'd3) ? c[2] : c[1]);
            quat_next[3] = (in_data.idx == 2'd3) ? last : c[2];
        end
    end

    assign in_ready  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;

    assign kept_out_0        = kept_reg[0];
    assign kept_out_1        = kept_reg[1];
    assign kept_out_2        = kept_reg[2];
    assign dropped_index_out = idx_reg;
    assign dropped_sign_out  = sign_reg;
    assign quat_out_0        = quat_reg[0];
    assign quat_out_1        = quat_reg[1];
    assign quat_out_2        = quat_reg[2];
    assign quat_out_3        = quat_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg   <= in_data.op;
            kept_reg <= kept_next;
            idx_reg  <= idx_next;
            sign_reg <= sign_next;
            quat_reg <= quat_next;
        end
    end

    // Fields the operation does not drive read zero
    a_pack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && op_reg == OP_PACK) |-> (quat_reg == '0))
        else $error("pack result has nonzero quaternion fields");

    a_unpack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && op_reg == OP_UNPACK) |->
            (kept_reg == '0 && idx_reg == 2'd0 && !sign_reg))
        else $error("unpack result has nonzero compact fields");

    // A held result keeps its operation while stalled
    a_hold_op: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |=> (valid_reg && $stable(op_reg) && $stable(quat_reg)))
        else $error("stalled result changed");

endmodule
